// ===== src/mcg_pkg.sv =====
// Package for the midpoint circle generator: shared constants and opcodes.
// No dependencies; the top level, front end, queue and back end import it.
package mcg_pkg;

	// Default widths of the radius and of the center coordinates
	localparam int RADIUS_BITS_DEF = 10;
	localparam int COORD_BITS_DEF  = 12;

	// Command opcodes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// Eight mirrored pixels per step
	localparam int PIX_PER_STEP = 8;
	localparam int IDX_BITS     = $clog2(PIX_PER_STEP);
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIX_PER_STEP - 1);

	// Step queue between the front and the back
	localparam int QUEUE_DEPTH = 2;

endpackage

// ===== src/mcg_cmd_if.sv =====
// Command channel of the midpoint circle generator (start / advance beats).
// Depends on nothing; widths come from its parameters.
interface mcg_cmd_if #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
);
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic [RADIUS_BITS-1:0]       radius;

	modport source (output valid, op, center_x, center_y, radius, input ready);
	modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

// ===== src/mcg_pix_if.sv =====
// Pixel channel of the midpoint circle generator, one pixel per beat.
// Depends on nothing; widths come from its parameter.
interface mcg_pix_if #(
	parameter int PIX_BITS = 13
);
	logic                       valid;
	logic                       ready;
	logic signed [PIX_BITS-1:0] pixel_x;
	logic signed [PIX_BITS-1:0] pixel_y;
	logic                       last_of_step;
	logic                       circle_done;

	modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface

// ===== src/midpoint_circle_generator.sv =====
// Midpoint circle generator, top level: front end, step queue, pixel back end.
// A step's first pixel passes the queue, the back end's descriptor hold and its output register.
// Throughput: one pixel per cycle while the sink takes them, with the back end emitting
// the eight mirrored pixels in sequence; commands are taken while the two-entry queue has room.
// Reset (arst_n low, asynchronous): no circle active, queue and output empty.
module midpoint_circle_generator #(
	parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF,
	parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mcg_cmd_if.sink     cmd,
	mcg_pix_if.source   pix
);
	import mcg_pkg::*;

	localparam int QW = 2 * COORD_BITS + 2 * RADIUS_BITS + 2;

	logic                         push, pop, full, empty;
	logic signed [COORD_BITS-1:0] f_cx, f_cy, b_cx, b_cy;
	logic [RADIUS_BITS-1:0]       f_x, b_x;
	logic signed [RADIUS_BITS:0]  f_y, b_y;
	logic                         f_done, b_done;
	logic [QW-1:0]                q_wdata, q_rdata;

	mcg_front #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.full     (full),
		.push     (push),
		.step_cx  (f_cx),
		.step_cy  (f_cy),
		.step_x   (f_x),
		.step_y   (f_y),
		.step_done(f_done)
	);

	assign q_wdata = {f_cx, f_cy, f_x, f_y, f_done};

	mcg_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.full  (full),
		.pop   (pop),
		.rdata (q_rdata),
		.empty (empty)
	);

	assign {b_cx, b_cy, b_x, b_y, b_done} = q_rdata;

	mcg_back #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.step_cx  (b_cx),
		.step_cy  (b_cy),
		.step_x   (b_x),
		.step_y   (b_y),
		.step_done(b_done),
		.pop      (pop),
		.pix      (pix)
	);

endmodule

// ===== src/mcg_front.sv =====
// Front end: accepts command beats, holds the circle state and runs the
// midpoint update, pushing one step descriptor per plotted step. Uses mcg_pkg.
module mcg_front #(
	parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF,
	parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mcg_cmd_if.sink                      cmd,
	input  logic                         full,
	output logic                         push,
	output logic signed [COORD_BITS-1:0] step_cx,
	output logic signed [COORD_BITS-1:0] step_cy,
	output logic [RADIUS_BITS-1:0]       step_x,
	output logic signed [RADIUS_BITS:0]  step_y,
	output logic                         step_done
);
	import mcg_pkg::*;

	localparam int RB = RADIUS_BITS;
	localparam int DW = RADIUS_BITS + 3;	// decision value width
	localparam int CW = RADIUS_BITS + 2;	// compare width for x against y

	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [RB-1:0]                x_q;
	logic signed [RB:0]           y_q;
	logic signed [DW-1:0]         p_q;
	logic                         active_q;

	logic                         accept, start;
	logic [RB-1:0]                bx, xn;
	logic signed [RB:0]           by, yn;
	logic signed [DW-1:0]         bp, pn, xe, ye, rz;
	logic                         bact, step_ok, done;

	assign cmd.ready = !full;
	assign accept    = cmd.valid && cmd.ready;
	assign start     = (cmd.op == OP_START);

	// Starting point: fresh circle on start, held state on advance
	always_comb begin
		rz   = signed'({{(DW-RB){1'b0}}, cmd.radius});
		bx   = start ? '0 : x_q;
		by   = start ? signed'({1'b0, cmd.radius}) : y_q;
		bp   = start ? (DW'(1) - rz) : p_q;
		bact = start || active_q;
	end

	// Midpoint update; both branches use the new x, the decrementing branch also the new y
	always_comb begin
		step_ok = bact && (signed'({2'b00, bx}) <= signed'({by[RB], by}));
		xn      = bx + RB'(1);
		yn      = (bp < 0) ? by : (by - (RB+1)'(1));
		xe      = signed'({{(DW-RB){1'b0}}, xn});
		ye      = signed'({{(DW-RB-1){yn[RB]}}, yn});
		if (bp < 0) begin
			pn = bp + xe + xe + DW'(1);
		end else begin
			pn = bp + xe + xe - ye - ye + DW'(1);
		end
		done = signed'(CW'({2'b00, xn})) > signed'({yn[RB], yn});
	end

	// Descriptor of the step whose pixels the back end emits
	assign push      = accept && step_ok;
	assign step_cx   = start ? cmd.center_x : cx_q;
	assign step_cy   = start ? cmd.center_y : cy_q;
	assign step_x    = bx;
	assign step_y    = by;
	assign step_done = done;

	// Circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			p_q      <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (start) begin
				cx_q <= cmd.center_x;
				cy_q <= cmd.center_y;
			end
			if (step_ok) begin
				x_q      <= xn;
				y_q      <= yn;
				p_q      <= pn;
				active_q <= !done;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/mcg_queue.sv =====
// Short step queue between the front end and the pixel back end.
// Uses mcg_pkg for its depth.
module mcg_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import mcg_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;

	assign full  = (cnt_q == NW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

// ===== src/mcg_back.sv =====
// Back end: takes one step descriptor and emits its eight mirrored pixels,
// one per cycle while the sink takes them, through a registered output stage. Uses mcg_pkg.
module mcg_back #(
	parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF,
	parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  logic signed [COORD_BITS-1:0] step_cx,
	input  logic signed [COORD_BITS-1:0] step_cy,
	input  logic [RADIUS_BITS-1:0]       step_x,
	input  logic signed [RADIUS_BITS:0]  step_y,
	input  logic                         step_done,
	output logic                         pop,
	mcg_pix_if.source                    pix
);
	import mcg_pkg::*;

	localparam int RB = RADIUS_BITS;
	localparam int PB = COORD_BITS + 1;
	localparam int SW = (PB > RB + 2) ? PB : RB + 2;	// sum width before wrap

	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [RB-1:0]                x_q;
	logic signed [RB:0]           y_q;
	logic                         done_q;
	logic                         busy_q;
	logic [IDX_BITS-1:0]          idx_q;

	logic                         ovalid_q, olast_q, odone_q;
	logic signed [PB-1:0]         opx_q, opy_q;

	logic                         adv, emit, step_end, last;
	logic [SW-1:0]                sx, sy, ux, uy, u, v, px, py;

	// Output stage moves when empty or when the sink takes the beat
	assign adv      = !ovalid_q || pix.ready;
	assign emit     = busy_q && adv;
	assign last     = (idx_q == LAST_IDX);
	assign step_end = emit && last;
	assign pop      = !empty && (!busy_q || step_end);

	// Mirror select: bit 2 swaps x and y, bit 0 negates u, bit 1 negates v
	always_comb begin
		sx = {{(SW-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q};
		sy = {{(SW-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q};
		ux = {{(SW-RB){1'b0}}, x_q};
		uy = {{(SW-RB-1){y_q[RB]}}, y_q};
		u  = idx_q[2] ? uy : ux;
		v  = idx_q[2] ? ux : uy;
		px = idx_q[0] ? (sx - u) : (sx + u);
		py = idx_q[1] ? (sy - v) : (sy + v);
	end

	// Step sequencer and descriptor hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (step_end) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (emit) begin
			idx_q <= idx_q + IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q   <= step_cx;
			cy_q   <= step_cy;
			x_q    <= step_x;
			y_q    <= step_y;
			done_q <= step_done;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			opx_q   <= signed'(px[PB-1:0]);
			opy_q   <= signed'(py[PB-1:0]);
			olast_q <= last;
			odone_q <= last && done_q;
		end
	end

	assign pix.valid        = ovalid_q;
	assign pix.pixel_x      = opx_q;
	assign pix.pixel_y      = opy_q;
	assign pix.last_of_step = olast_q;
	assign pix.circle_done  = odone_q;

endmodule
